/* rtl/ctv_pkg.sv */
package ctv_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
	localparam int LIMIT_W = 62;
	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [6:0] EXPIRED_MAX = 7'd127;

	typedef enum logic [2:0] {
		KIND_OPEN  = 3'd0,
		KIND_ACK   = 3'd1,
		KIND_DATA  = 3'd2,
		KIND_CLOSE = 3'd3,
		KIND_SWEEP = 3'd4
	} msg_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_SRC_LIMIT = 3'd1,
		ERR_EXISTS    = 3'd2,
		ERR_NOT_FOUND = 3'd3,
		ERR_QUOTA     = 3'd4,
		ERR_BAD_KIND  = 3'd5,
		ERR_FULL      = 3'd6
	} err_code_t;

	typedef enum logic [1:0] {
		CFG_SRC_LIMIT  = 2'd0,
		CFG_BYTE_QUOTA = 2'd1,
		CFG_TIMEOUT    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] payload_length;
		logic [62:0] current_time;
	} ctv_in_t;

	typedef struct packed {
		logic       accepted;
		logic [2:0] error_code;
		logic [6:0] expired_count;
	} ctv_out_t;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [62:0] touched_at;
		logic [31:0] byte_total;
	} slot_entry_t;

	typedef struct packed {
		logic src_hit;
		logic pair_hit;
		logic expired;
	} slot_eval_t;

endpackage

/* rtl/ctv_ram.sv */
module ctv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/ctv_slot_eval.sv */
module ctv_slot_eval (
	input  logic                      valid,
	input  ctv_pkg::slot_entry_t      entry,
	input  logic [31:0]               count_src,
	input  logic [31:0]               key_src,
	input  logic [31:0]               key_dst,
	input  logic [62:0]               now,
	input  logic [ctv_pkg::LIMIT_W-1:0] limit,
	output ctv_pkg::slot_eval_t       eval
);
	import ctv_pkg::*;

	logic [62:0] idle_time;
	logic        later;

	assign later     = now > entry.touched_at;
	assign idle_time = now - entry.touched_at;

	always_comb begin
		eval.src_hit  = valid && (entry.src == count_src);
		eval.pair_hit = valid && (entry.src == key_src) && (entry.dst == key_dst);
		eval.expired  = valid && later && (idle_time > 63'(limit));
	end

endmodule

/* rtl/connection_tracking_validator.sv */
// Connection tracking validator: keeps a 64-slot connection table and answers every
// transaction with exactly one result (accepted, error code, expired count). Each
// valid kind walks the whole table through the single slot compare unit, one slot
// per cycle from the table RAM, then goes through the flush and decide steps; an
// unrecognized kind goes straight to the decide step. in_stall stays high while an
// item is in progress; a finished result waits in the output register, holding up
// only the next item's decide step. Configuration must be written while idle (not
// enforced by the block); writes to an index beyond the register list are ignored.
module connection_tracking_validator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ctv_pkg::ctv_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ctv_pkg::ctv_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import ctv_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_DECIDE
	} state_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	state_t               state_q;
	ctv_in_t              req_q;
	logic [31:0]          key_src_q;
	logic [31:0]          key_dst_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [LIMIT_W-1:0]   limit_d;
	logic [6:0]           src_limit_q;
	logic [31:0]          quota_q;
	logic [31:0]          timeout_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]     addr_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [CNT_W-1:0]     src_cnt_q;
	logic                 found_q;
	logic [IDX_W-1:0]     hit_idx_q;
	slot_entry_t          hit_entry_q;
	logic                 free_found_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [6:0]           exp_cnt_q;
	logic                 out_valid_q;
	ctv_out_t             out_q;

	logic [ENTRY_W-1:0]   rd_data;
	slot_entry_t          rd_entry;
	slot_eval_t           eval;
	logic                 slot_valid;
	logic                 accept;
	logic                 out_free;
	logic                 finish;

	err_code_t            err_d;
	logic                 wr_en_d;
	logic [IDX_W-1:0]     wr_addr_d;
	slot_entry_t          wr_entry_d;
	logic                 set_valid_d;
	logic                 clr_valid_d;
	logic [32:0]          bytes_sum;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == ST_DECIDE) && out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign limit_d  = LIMIT_W'(timeout_q) * LIMIT_W'(NS_PER_SEC);
	assign rd_entry = slot_entry_t'(rd_data);
	assign slot_valid = valid_q[idx_s1];
	assign bytes_sum = {1'b0, hit_entry_q.byte_total} + 33'(req_q.payload_length);

	ctv_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (finish && wr_en_d),
		.waddr(wr_addr_d),
		.wdata(wr_entry_d),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	ctv_slot_eval u_eval (
		.valid    (slot_valid),
		.entry    (rd_entry),
		.count_src(req_q.source_address),
		.key_src  (key_src_q),
		.key_dst  (key_dst_q),
		.now      (req_q.current_time),
		.limit    (limit_q),
		.eval     (eval)
	);

	always_comb begin
		err_d       = ERR_NONE;
		wr_en_d     = 1'b0;
		wr_addr_d   = hit_idx_q;
		wr_entry_d  = hit_entry_q;
		set_valid_d = 1'b0;
		clr_valid_d = 1'b0;
		unique case (req_q.kind)
			KIND_OPEN: begin
				wr_addr_d = free_idx_q;
				wr_entry_d.src = req_q.source_address;
				wr_entry_d.dst = req_q.dest_address;
				wr_entry_d.touched_at = req_q.current_time;
				wr_entry_d.byte_total = '0;
				if (CMP_W'(src_cnt_q) >= CMP_W'(src_limit_q)) begin
					err_d = ERR_SRC_LIMIT;
				end else if (found_q) begin
					err_d = ERR_EXISTS;
				end else if (!free_found_q) begin
					err_d = ERR_FULL;
				end else begin
					wr_en_d     = 1'b1;
					set_valid_d = 1'b1;
				end
			end
			KIND_ACK: begin
				wr_entry_d.touched_at = req_q.current_time;
				if (!found_q) begin
					err_d = ERR_NOT_FOUND;
				end else begin
					wr_en_d = 1'b1;
				end
			end
			KIND_DATA: begin
				wr_entry_d.touched_at = req_q.current_time;
				wr_entry_d.byte_total = bytes_sum[31:0];
				if (!found_q) begin
					err_d = ERR_NOT_FOUND;
				end else if (req_q.payload_length != '0) begin
					if (bytes_sum > {1'b0, quota_q}) begin
						err_d = ERR_QUOTA;
					end else begin
						wr_en_d = 1'b1;
					end
				end
			end
			KIND_CLOSE: begin
				if (!found_q) begin
					err_d = ERR_NOT_FOUND;
				end else begin
					clr_valid_d = 1'b1;
				end
			end
			KIND_SWEEP: begin
				err_d = ERR_NONE;
			end
			default: begin
				err_d = ERR_BAD_KIND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			addr_q       <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
			src_limit_q  <= 7'd4;
			quota_q      <= 32'd1048576;
			timeout_q    <= 32'd30;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			src_cnt_q    <= '0;
			exp_cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SRC_LIMIT:  src_limit_q <= cfg_data[6:0];
					CFG_BYTE_QUOTA: quota_q <= cfg_data;
					CFG_TIMEOUT:    timeout_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall && !finish) begin
				out_valid_q <= 1'b0;
			end

			rd_vld_s1 <= state_q == ST_SCAN;
			idx_s1    <= addr_q;

			// per-slot accumulation, one slot per cycle
			if (rd_vld_s1) begin
				if (eval.src_hit && (src_cnt_q != CNT_W'(TABLE_ENTRIES))) begin
					src_cnt_q <= src_cnt_q + 1'b1;
				end
				if (eval.pair_hit && !found_q) begin
					found_q     <= 1'b1;
					hit_idx_q   <= idx_s1;
					hit_entry_q <= rd_entry;
				end
				if (!slot_valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
				if (req_q.kind == KIND_SWEEP && eval.expired) begin
					valid_q[idx_s1] <= 1'b0;
					if (exp_cnt_q != EXPIRED_MAX) begin
						exp_cnt_q <= exp_cnt_q + 1'b1;
					end
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q        <= in_data;
						limit_q      <= limit_d;
						addr_q       <= '0;
						src_cnt_q    <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						exp_cnt_q    <= '0;
						if (in_data.kind == KIND_ACK) begin
							key_src_q <= in_data.dest_address;
							key_dst_q <= in_data.source_address;
						end else begin
							key_src_q <= in_data.source_address;
							key_dst_q <= in_data.dest_address;
						end
						if (in_data.kind > KIND_SWEEP) begin
							state_q <= ST_DECIDE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (out_free) begin
						if (set_valid_d) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						if (clr_valid_d) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
						out_valid_q         <= 1'b1;
						out_q.accepted      <= err_d == ERR_NONE;
						out_q.error_code    <= err_d;
						out_q.expired_count <= (req_q.kind == KIND_SWEEP) ? exp_cnt_q : 7'd0;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DECIDE))
		else $error("result appeared outside the decide step");

	a_accept_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.accepted == (out_q.error_code == ERR_NONE)))
		else $error("accepted flag disagrees with error code");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("block idle right after accepting a transaction");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
		else $error("table read data outside the scan");

endmodule
